@@ src/onpa_pkg.sv @@
package onpa_pkg;

	// Field and datapath widths.
	localparam int DATA_W      = 32;
	localparam int SQ_W        = 2 * DATA_W;
	localparam int ROOT_STAGES = DATA_W;
	localparam int UNIT_SH     = DATA_W - 2;
	localparam int QUO_W       = DATA_W - 1;
	localparam int NUM_W       = DATA_W + UNIT_SH;
	localparam int LANES       = 3;

	// Angle datapath: 2^31 stands for pi.
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_PRE   = 60 - DATA_W;
	localparam int ANG_W        = DATA_W + 3;
	localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(64'sd2147483648);
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd1073741824);

	// Pipeline depths.
	localparam int LATE_STAGES = 32;
	localparam int PIPE_STAGES = 2 + ROOT_STAGES + LATE_STAGES;

	// Side data carried alongside the square root stages.
	typedef struct packed {
		logic [LANES-1:0]             dir_neg;
		logic [LANES-1:0][DATA_W-1:0] dir_mag;
		logic [DATA_W-1:0]            pz;
	} early_t;

	// Side data carried alongside the divide and angle stages.
	typedef struct packed {
		logic [LANES-1:0]  dir_neg;
		logic [DATA_W-1:0] len;
		logic [DATA_W-1:0] rad;
	} late_t;

	// One result item.
	typedef struct packed {
		logic [DATA_W-1:0] unit_x;
		logic [DATA_W-1:0] unit_y;
		logic [DATA_W-1:0] unit_z;
		logic [DATA_W-1:0] dir_length;
		logic [DATA_W-1:0] radius;
		logic [DATA_W-1:0] polar_angle;
		logic              zero_direction;
	} res_t;

	// Magnitude of a signed word as an unsigned word of the same width.
	function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] r;
		r = v[DATA_W-1] ? DATA_W'(0 - v) : v;
		return r;
	endfunction

	// Arctangent of 2^-i, scaled so that 2^31 is pi.
	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051D;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2E;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000002;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

@@ src/onpa_sqrt.sv @@
module onpa_sqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [onpa_pkg::SQ_W-1:0]  rad_in,
	output logic [onpa_pkg::DATA_W-1:0] root
);
	import onpa_pkg::*;

	localparam int REM_W = DATA_W + 2;

	logic [SQ_W-1:0]   n_s   [ROOT_STAGES];
	logic [REM_W-1:0]  rem_s [ROOT_STAGES];
	logic [DATA_W-1:0] q_s   [ROOT_STAGES];

	// One root bit per stage, most significant first.
	for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_st
		localparam int B = ROOT_STAGES - 1 - i;
		logic [SQ_W-1:0]   n_in;
		logic [REM_W-1:0]  r_in;
		logic [DATA_W-1:0] q_in;
		logic [REM_W+1:0]  r_sh;
		logic [REM_W+1:0]  trial;
		logic              ge;

		if (i == 0) begin : g_first
			assign n_in = rad_in;
			assign r_in = '0;
			assign q_in = '0;
		end else begin : g_next
			assign n_in = n_s[i-1];
			assign r_in = rem_s[i-1];
			assign q_in = q_s[i-1];
		end

		assign r_sh  = {r_in, n_in[2*B+1 -: 2]};
		assign trial = {2'b00, q_in, 2'b01};
		assign ge    = (r_sh >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i]   <= n_in;
				rem_s[i] <= ge ? REM_W'(r_sh - trial) : REM_W'(r_sh);
				q_s[i]   <= {q_in[DATA_W-2:0], ge};
			end
		end
	end

	assign root = q_s[ROOT_STAGES-1];

endmodule

@@ src/onpa_div_lane.sv @@
module onpa_div_lane (
	input  logic                        clk,
	input  logic                        en,
	input  logic [onpa_pkg::DATA_W-1:0] mag,
	input  logic [onpa_pkg::DATA_W-1:0] len,
	output logic [onpa_pkg::QUO_W-1:0]  quo
);
	import onpa_pkg::*;

	logic [NUM_W-1:0]  num_s0;
	logic [DATA_W-1:0] len_s0;

	logic [NUM_W-1:0]  num_s [QUO_W];
	logic [DATA_W-1:0] len_s [QUO_W];
	logic [DATA_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0]  q_s   [QUO_W];

	// Rounded numerator: magnitude shifted up by UNIT_SH bits for a Q1.30 quotient, plus half the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			num_s0 <= {mag, {UNIT_SH{1'b0}}} + NUM_W'(len >> 1);
			len_s0 <= len;
		end
	end

	// Restoring division, one quotient bit per stage. The quotient never
	// exceeds one in Q1.30, so the upper numerator bits seed the remainder.
	for (genvar j = 0; j < QUO_W; j++) begin : g_st
		localparam int B = QUO_W - 1 - j;
		logic [NUM_W-1:0]  num_in;
		logic [DATA_W-1:0] len_in;
		logic [DATA_W-1:0] rem_in;
		logic [QUO_W-1:0]  q_in;
		logic [DATA_W:0]   r2;
		logic              ge;

		if (j == 0) begin : g_first
			assign num_in = num_s0;
			assign len_in = len_s0;
			assign rem_in = DATA_W'(num_s0[NUM_W-1:QUO_W]);
			assign q_in   = '0;
		end else begin : g_next
			assign num_in = num_s[j-1];
			assign len_in = len_s[j-1];
			assign rem_in = rem_s[j-1];
			assign q_in   = q_s[j-1];
		end

		assign r2 = {rem_in, num_in[B]};
		assign ge = (r2 >= {1'b0, len_in});

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[j] <= num_in;
				len_s[j] <= len_in;
				rem_s[j] <= ge ? DATA_W'(r2 - {1'b0, len_in}) : DATA_W'(r2);
				q_s[j]   <= {q_in[QUO_W-2:0], ge};
			end
		end
	end

	assign quo = q_s[QUO_W-1];

endmodule

@@ src/onpa_cordic.sv @@
module onpa_cordic (
	input  logic                        clk,
	input  logic                        en,
	input  logic [onpa_pkg::DATA_W-1:0] pz,
	input  logic [onpa_pkg::DATA_W-1:0] rho,
	output logic [onpa_pkg::DATA_W-1:0] angle
);
	import onpa_pkg::*;

	localparam int XY_W = 64;

	logic signed [XY_W-1:0]  x_s0;
	logic signed [XY_W-1:0]  y_s0;
	logic signed [ANG_W-1:0] ang_s0;
	logic                    spec_s0;
	logic                    zneg_s0;

	logic signed [XY_W-1:0]  x_s   [CORDIC_STEPS];
	logic signed [XY_W-1:0]  y_s   [CORDIC_STEPS];
	logic signed [ANG_W-1:0] ang_s [CORDIC_STEPS];
	logic                    spec_s [CORDIC_STEPS];
	logic                    zneg_s [CORDIC_STEPS];

	logic [DATA_W-1:0] angle_q;
	logic              zneg;
	logic [DATA_W-1:0] zmag;

	assign zneg = pz[DATA_W-1];
	assign zmag = magnitude(pz);

	// Setup: turn a vector below the xy plane by a quarter turn, then prescale.
	always_ff @(posedge clk) begin
		if (en) begin
			if (zneg) begin
				x_s0   <= XY_W'({32'd0, rho}) <<< CORDIC_PRE;
				y_s0   <= XY_W'({32'd0, zmag}) <<< CORDIC_PRE;
				ang_s0 <= ANG_HALF_PI;
			end else begin
				x_s0   <= XY_W'(signed'(pz)) <<< CORDIC_PRE;
				y_s0   <= XY_W'({32'd0, rho}) <<< CORDIC_PRE;
				ang_s0 <= '0;
			end
			spec_s0 <= (rho == '0);
			zneg_s0 <= zneg;
		end
	end

	// Vectoring iterations, one per stage.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_st
		logic signed [XY_W-1:0]  x_in;
		logic signed [XY_W-1:0]  y_in;
		logic signed [ANG_W-1:0] a_in;
		logic                    sp_in;
		logic                    zn_in;
		logic signed [XY_W-1:0]  xs;
		logic signed [XY_W-1:0]  ys;
		logic signed [ANG_W-1:0] step;

		if (i == 0) begin : g_first
			assign x_in  = x_s0;
			assign y_in  = y_s0;
			assign a_in  = ang_s0;
			assign sp_in = spec_s0;
			assign zn_in = zneg_s0;
		end else begin : g_next
			assign x_in  = x_s[i-1];
			assign y_in  = y_s[i-1];
			assign a_in  = ang_s[i-1];
			assign sp_in = spec_s[i-1];
			assign zn_in = zneg_s[i-1];
		end

		assign xs   = x_in >>> i;
		assign ys   = y_in >>> i;
		assign step = ANG_W'(atan_entry(5'(i)));

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_in[XY_W-1]) begin
					x_s[i]   <= x_in + ys;
					y_s[i]   <= y_in - xs;
					ang_s[i] <= a_in + step;
				end else begin
					x_s[i]   <= x_in - ys;
					y_s[i]   <= y_in + xs;
					ang_s[i] <= a_in - step;
				end
				spec_s[i] <= sp_in;
				zneg_s[i] <= zn_in;
			end
		end
	end

	// Final clamp to [0, pi], with the on-axis cases taken apart.
	always_ff @(posedge clk) begin
		if (en) begin
			if (spec_s[CORDIC_STEPS-1]) begin
				angle_q <= zneg_s[CORDIC_STEPS-1] ? DATA_W'(ANG_PI) : '0;
			end else if (ang_s[CORDIC_STEPS-1] < 0) begin
				angle_q <= '0;
			end else if (ang_s[CORDIC_STEPS-1] > ANG_PI) begin
				angle_q <= DATA_W'(ANG_PI);
			end else begin
				angle_q <= DATA_W'(ang_s[CORDIC_STEPS-1]);
			end
		end
	end

	assign angle = angle_q;

endmodule

@@ src/orientation_normalize_polar_angle_core.sv @@
// Dipole vector normalizer with polar angle.
// Input channel (in_valid / in_stall) carries one dipole per transfer: the
// position pos_x/y/z and orientation dir_x/y/z, signed Q15.16.
// Output channel (out_valid / out_stall) carries one result per input: the
// orientation scaled to unit length (Q1.30), its length and the position
// radius (Q16.16), the polar angle from +z (2^31 is pi) and a flag for a zero
// orientation, in which case the unit components are zero.
// The pipeline depth comes from the square roots and the unit divides, each
// of which resolves one bit per pipeline stage; the angle pipeline runs beside
// the divides. Throughput: one item per cycle while in_stall is low.
// When the receiver stalls, one more result is caught in a skid register and
// in_stall rises on the next cycle, freezing the pipeline until the output
// register drains. Reset clears all valid flags; no result is pending after
// reset and the block takes input in the first cycle.
module orientation_normalize_polar_angle_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [onpa_pkg::DATA_W-1:0] pos_x,
	input  logic signed [onpa_pkg::DATA_W-1:0] pos_y,
	input  logic signed [onpa_pkg::DATA_W-1:0] pos_z,
	input  logic signed [onpa_pkg::DATA_W-1:0] dir_x,
	input  logic signed [onpa_pkg::DATA_W-1:0] dir_y,
	input  logic signed [onpa_pkg::DATA_W-1:0] dir_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [onpa_pkg::DATA_W-1:0] unit_x,
	output logic signed [onpa_pkg::DATA_W-1:0] unit_y,
	output logic signed [onpa_pkg::DATA_W-1:0] unit_z,
	output logic        [onpa_pkg::DATA_W-1:0] dir_length,
	output logic        [onpa_pkg::DATA_W-1:0] radius,
	output logic        [onpa_pkg::DATA_W-1:0] polar_angle,
	output logic                               zero_direction
);
	import onpa_pkg::*;

	logic                   en;
	logic                   in_take;
	logic                   out_take;
	logic                   emit;
	logic [PIPE_STAGES-1:0] vld_q;
	logic                   skid_vld_q;
	logic                   out_vld_q;
	res_t                   skid_q;
	res_t                   out_q;
	res_t                   tail_res;

	logic [LANES-1:0][DATA_W-1:0] in_dir;
	logic [SQ_W-1:0]              sq_s1 [2*LANES];
	early_t                       early_s1;
	logic [SQ_W-1:0]              dsum_s2;
	logic [SQ_W-1:0]              xy_s2;
	logic [SQ_W-1:0]              rsum_s2;
	early_t                       early_s2;
	early_t                       early_dly_s [ROOT_STAGES];
	late_t                        late_dly_s  [LATE_STAGES];
	late_t                        late_in;

	logic [DATA_W-1:0]            len_root;
	logic [DATA_W-1:0]            rad_root;
	logic [DATA_W-1:0]            rho_root;
	logic [LANES-1:0][QUO_W-1:0]  quo;
	logic [DATA_W-1:0]            angle;
	logic [LANES-1:0][DATA_W-1:0] unit_res;

	// Pipeline moves whenever the skid register is empty.
	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;
	assign in_take  = in_valid && en;
	assign out_take = out_vld_q && !out_stall;
	assign emit     = en && vld_q[PIPE_STAGES-1];

	assign in_dir = {dir_z, dir_y, dir_x};

	// Stage 1: magnitudes and squares.
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1[0] <= magnitude(dir_x) * magnitude(dir_x);
			sq_s1[1] <= magnitude(dir_y) * magnitude(dir_y);
			sq_s1[2] <= magnitude(dir_z) * magnitude(dir_z);
			sq_s1[3] <= magnitude(pos_x) * magnitude(pos_x);
			sq_s1[4] <= magnitude(pos_y) * magnitude(pos_y);
			sq_s1[5] <= magnitude(pos_z) * magnitude(pos_z);
			for (int k = 0; k < LANES; k++) begin
				early_s1.dir_neg[k] <= in_dir[k][DATA_W-1];
				early_s1.dir_mag[k] <= magnitude(in_dir[k]);
			end
			early_s1.pz <= pos_z;
		end
	end

	// Stage 2: sums of squares.
	always_ff @(posedge clk) begin
		if (en) begin
			dsum_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			xy_s2    <= sq_s1[3] + sq_s1[4];
			rsum_s2  <= sq_s1[3] + sq_s1[4] + sq_s1[5];
			early_s2 <= early_s1;
		end
	end

	// Square roots for the orientation length, radius and xy radius.
	onpa_sqrt u_sqrt_len (.clk(clk), .en(en), .rad_in(dsum_s2), .root(len_root));
	onpa_sqrt u_sqrt_rad (.clk(clk), .en(en), .rad_in(rsum_s2), .root(rad_root));
	onpa_sqrt u_sqrt_rho (.clk(clk), .en(en), .rad_in(xy_s2),   .root(rho_root));

	// Side data follows the root stages.
	always_ff @(posedge clk) begin
		if (en) begin
			early_dly_s[0] <= early_s2;
			for (int i = 1; i < ROOT_STAGES; i++) begin
				early_dly_s[i] <= early_dly_s[i-1];
			end
		end
	end

	// One divide lane per orientation component.
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		onpa_div_lane u_lane (
			.clk (clk),
			.en  (en),
			.mag (early_dly_s[ROOT_STAGES-1].dir_mag[k]),
			.len (len_root),
			.quo (quo[k])
		);
	end

	// Polar angle from the z component and the xy radius.
	onpa_cordic u_cordic (
		.clk   (clk),
		.en    (en),
		.pz    (early_dly_s[ROOT_STAGES-1].pz),
		.rho   (rho_root),
		.angle (angle)
	);

	// Side data follows the divide and angle stages.
	assign late_in.dir_neg = early_dly_s[ROOT_STAGES-1].dir_neg;
	assign late_in.len     = len_root;
	assign late_in.rad     = rad_root;

	always_ff @(posedge clk) begin
		if (en) begin
			late_dly_s[0] <= late_in;
			for (int i = 1; i < LATE_STAGES; i++) begin
				late_dly_s[i] <= late_dly_s[i-1];
			end
		end
	end

	// Merge the lanes: apply signs and the zero orientation case.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			if (late_dly_s[LATE_STAGES-1].len == '0) begin
				unit_res[k] = '0;
			end else if (late_dly_s[LATE_STAGES-1].dir_neg[k]) begin
				unit_res[k] = DATA_W'(0 - {1'b0, quo[k]});
			end else begin
				unit_res[k] = DATA_W'(quo[k]);
			end
		end
		tail_res.unit_x         = unit_res[0];
		tail_res.unit_y         = unit_res[1];
		tail_res.unit_z         = unit_res[2];
		tail_res.dir_length     = late_dly_s[LATE_STAGES-1].len;
		tail_res.radius         = late_dly_s[LATE_STAGES-1].rad;
		tail_res.polar_angle    = angle;
		tail_res.zero_direction = (late_dly_s[LATE_STAGES-1].len == '0);
	end

	// Valid flags through the pipeline, output register and skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[PIPE_STAGES-2:0], in_take};
			end
			if (skid_vld_q) begin
				if (out_take) begin
					skid_vld_q <= 1'b0;
				end
			end else if (emit) begin
				if (!out_vld_q || out_take) begin
					out_vld_q <= 1'b1;
				end else begin
					skid_vld_q <= 1'b1;
				end
			end else if (out_take) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Result data for the output and skid registers.
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (emit) begin
			if (!out_vld_q || out_take) begin
				out_q <= tail_res;
			end else begin
				skid_q <= tail_res;
			end
		end
	end

	assign out_valid      = out_vld_q;
	assign unit_x         = out_q.unit_x;
	assign unit_y         = out_q.unit_y;
	assign unit_z         = out_q.unit_z;
	assign dir_length     = out_q.dir_length;
	assign radius         = out_q.radius;
	assign polar_angle    = out_q.polar_angle;
	assign zero_direction = out_q.zero_direction;

endmodule
